FILE: rtl/core/lpr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line pixel rasterizer package
// Shared types and constants for the line rasterizer core.
// ----------------------------------------------------------------------------
package lpr_pkg;

   localparam int FRAME_WIDTH = 160;

   localparam int COL_W  = 8;
   localparam int ROW_W  = 7;
   localparam int ADDR_W = 15;
   localparam int PIX_W  = 8;
   localparam int ERR_W  = 11;
   localparam int TWICE_W = 9;

   // Request data: start_x, start_y, end_x, end_y, pen_color, zero fill.
   localparam int REQ_DATA_W = 40;
   // Response data: pixel_col, pixel_row, pixel_address, pixel_value, zero fill.
   localparam int RSP_DATA_W = 40;

   typedef enum logic {
      MODE_START   = 1'b0,
      MODE_ADVANCE = 1'b1
   } lpr_mode_type;

   localparam logic signed [1:0] STEP_POS  = 2'sb01;
   localparam logic signed [1:0] STEP_NEG  = 2'sb11;
   localparam logic signed [1:0] STEP_NONE = 2'sb00;

   typedef struct packed {
      logic [COL_W-1:0]          start_x;
      logic [ROW_W-1:0]          start_y;
      logic [COL_W-1:0]          end_x;
      logic [ROW_W-1:0]          end_y;
      logic [PIX_W-1:0]          pen_color;
   } lpr_request_type;

   typedef struct packed {
      logic [COL_W-1:0]          cur_col;
      logic [ROW_W-1:0]          cur_row;
      logic [COL_W-1:0]          goal_col;
      logic [ROW_W-1:0]          goal_row;
      logic signed [1:0]         col_step;
      logic signed [1:0]         row_step;
      logic [TWICE_W-1:0]        twice_dx;
      logic [TWICE_W-1:0]        twice_dy;
      logic signed [ERR_W-1:0]   err_term;
      logic                      col_major;
      logic [PIX_W-1:0]          line_color;
   } lpr_line_type;

   typedef struct packed {
      logic                      valid;
      logic [COL_W-1:0]          col;
      logic [ROW_W-1:0]          row;
      logic [PIX_W-1:0]          color;
      logic                      last;
   } lpr_pixel_type;

endpackage

FILE: rtl/core/lpr_setup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line setup
// Derives deltas, step signs, major axis and initial error for a new line.
// ----------------------------------------------------------------------------
module lpr_setup (
   input  lpr_pkg::lpr_request_type req,
   output lpr_pkg::lpr_line_type    line,
   output logic                     at_end
);

   logic signed [lpr_pkg::COL_W:0] dx;
   logic signed [lpr_pkg::ROW_W:0] dy;
   logic [lpr_pkg::COL_W-1:0]      abs_dx;
   logic [lpr_pkg::ROW_W-1:0]      abs_dy;
   logic [lpr_pkg::TWICE_W-1:0]    twice_dx;
   logic [lpr_pkg::TWICE_W-1:0]    twice_dy;
   logic                           col_major;

   assign dx = $signed({1'b0, req.end_x}) - $signed({1'b0, req.start_x});
   assign dy = $signed({1'b0, req.end_y}) - $signed({1'b0, req.start_y});

   assign abs_dx = dx[lpr_pkg::COL_W] ? lpr_pkg::COL_W'(-dx) : dx[lpr_pkg::COL_W-1:0];
   assign abs_dy = dy[lpr_pkg::ROW_W] ? lpr_pkg::ROW_W'(-dy) : dy[lpr_pkg::ROW_W-1:0];

   assign twice_dx = {abs_dx, 1'b0};
   assign twice_dy = {1'b0, abs_dy, 1'b0};
   assign col_major = (twice_dx >= twice_dy);

   always_comb begin
      line.cur_col    = req.start_x;
      line.cur_row    = req.start_y;
      line.goal_col   = req.end_x;
      line.goal_row   = req.end_y;
      line.line_color = req.pen_color;
      line.twice_dx   = twice_dx;
      line.twice_dy   = twice_dy;
      line.col_major  = col_major;
      if (dx[lpr_pkg::COL_W]) begin
         line.col_step = lpr_pkg::STEP_NEG;
      end else if (dx != '0) begin
         line.col_step = lpr_pkg::STEP_POS;
      end else begin
         line.col_step = lpr_pkg::STEP_NONE;
      end
      if (dy[lpr_pkg::ROW_W]) begin
         line.row_step = lpr_pkg::STEP_NEG;
      end else if (dy != '0) begin
         line.row_step = lpr_pkg::STEP_POS;
      end else begin
         line.row_step = lpr_pkg::STEP_NONE;
      end
      // Half of the doubled major delta is the plain absolute delta.
      if (col_major) begin
         line.err_term = $signed({2'b00, twice_dy}) - $signed({3'b000, abs_dx});
      end else begin
         line.err_term = $signed({2'b00, twice_dx}) - $signed({4'b0000, abs_dy});
      end
   end

   assign at_end = (req.start_x == req.end_x) && (req.start_y == req.end_y);

endmodule

FILE: rtl/core/lpr_stepper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line stepper
// Holds the line state and advances it one pixel per advance request while a line is busy.
// ----------------------------------------------------------------------------
module lpr_stepper (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start_en,
   input  logic                     advance_en,
   input  lpr_pkg::lpr_line_type    setup_line,
   input  logic                     setup_at_end,
   output lpr_pkg::lpr_pixel_type   pixel,
   output logic                     busy
);

   lpr_pkg::lpr_line_type line_ff, line_in;
   logic busy_ff, busy_in;

   logic signed [lpr_pkg::ERR_W-1:0] tdx_s, tdy_s, err_q, err_major_add, err_next;
   logic                             major_pos, take_minor;
   logic [lpr_pkg::COL_W-1:0]        col_next;
   logic [lpr_pkg::ROW_W-1:0]        row_next;
   logic                             busy_adv;

   assign tdx_s = $signed({2'b00, line_ff.twice_dx});
   assign tdy_s = $signed({2'b00, line_ff.twice_dy});
   assign err_q = line_ff.err_term;

   assign major_pos = line_ff.col_major ? (line_ff.col_step == lpr_pkg::STEP_POS)
                                        : (line_ff.row_step == lpr_pkg::STEP_POS);
   // A zero error moves the minor axis only when the major axis runs forward.
   assign take_minor = !err_q[lpr_pkg::ERR_W-1] && ((err_q != '0) || major_pos);

   always_comb begin
      if (line_ff.col_major) begin
         err_major_add = err_q + tdy_s;
         err_next = take_minor ? (err_major_add - tdx_s) : err_major_add;
      end else begin
         err_major_add = err_q + tdx_s;
         err_next = take_minor ? (err_major_add - tdy_s) : err_major_add;
      end
   end

   always_comb begin
      if (line_ff.col_major || take_minor) begin
         col_next = line_ff.cur_col
                  + {{(lpr_pkg::COL_W-2){line_ff.col_step[1]}}, line_ff.col_step};
      end else begin
         col_next = line_ff.cur_col;
      end
      if (!line_ff.col_major || take_minor) begin
         row_next = line_ff.cur_row
                  + {{(lpr_pkg::ROW_W-2){line_ff.row_step[1]}}, line_ff.row_step};
      end else begin
         row_next = line_ff.cur_row;
      end
   end

   assign busy_adv = line_ff.col_major ? (col_next != line_ff.goal_col)
                                       : (row_next != line_ff.goal_row);

   always_comb begin
      line_in     = line_ff;
      busy_in     = busy_ff;
      pixel.valid = 1'b0;
      pixel.last  = 1'b0;
      if (start_en) begin
         line_in     = setup_line;
         busy_in     = !setup_at_end;
         pixel.valid = 1'b1;
         pixel.last  = setup_at_end;
      end else if (advance_en && busy_ff) begin
         line_in.cur_col  = col_next;
         line_in.cur_row  = row_next;
         line_in.err_term = err_next;
         busy_in          = busy_adv;
         pixel.valid      = 1'b1;
         pixel.last       = !busy_adv;
      end
      pixel.col   = line_in.cur_col;
      pixel.row   = line_in.cur_row;
      pixel.color = line_in.line_color;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff <= '0;
         busy_ff <= 1'b0;
      end else begin
         line_ff <= line_in;
         busy_ff <= busy_in;
      end
   end

   assign busy = busy_ff;

endmodule

FILE: rtl/core/line_pixel_rasterizer_core.sv
`timescale 1ns / 1ps
// Throughput: one request per cycle unless the response side stalls; each request passes once
// through the setup or step logic between the request register and the response register.
// Reset: synchronous, active high; clears both stage valids and the line state,
// leaving the rasterizer idle so that advance requests give no response.
// ----------------------------------------------------------------------------
// Line pixel rasterizer core
// Bresenham line drawing into a byte-per-pixel frame, at most one pixel per request.
// ----------------------------------------------------------------------------
module line_pixel_rasterizer_core #(
   parameter int FRAME_WIDTH = lpr_pkg::FRAME_WIDTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // start_x[7:0], start_y[14:8], end_x[22:15], end_y[29:23], pen_color[37:30]
   input  logic [lpr_pkg::REQ_DATA_W-1:0]     req_tdata,
   // mode[0]
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // pixel_col[7:0], pixel_row[14:8], pixel_address[29:15], pixel_value[37:30]
   output logic [lpr_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                               rsp_tlast
);

   localparam int REQ_USED_W = $bits(lpr_pkg::lpr_request_type);

   logic                      in_valid_ff, in_valid_in;
   lpr_pkg::lpr_request_type  in_req_ff;
   lpr_pkg::lpr_mode_type     in_mode_ff;
   lpr_pkg::lpr_request_type  req_fields;

   logic                      out_free, stage_adv;
   logic                      start_en, advance_en;

   lpr_pkg::lpr_line_type     setup_line;
   logic                      setup_at_end;
   lpr_pkg::lpr_pixel_type    pixel;
   logic                      busy;

   logic [lpr_pkg::ADDR_W-1:0] pixel_addr;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [lpr_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic                       rsp_last_ff;

   assign req_fields.start_x   = req_tdata[7:0];
   assign req_fields.start_y   = req_tdata[14:8];
   assign req_fields.end_x     = req_tdata[22:15];
   assign req_fields.end_y     = req_tdata[29:23];
   assign req_fields.pen_color = req_tdata[REQ_USED_W-1:30];

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign stage_adv  = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || stage_adv;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_req_ff  <= req_fields;
         in_mode_ff <= lpr_pkg::lpr_mode_type'(req_tuser);
      end
   end

   assign start_en   = stage_adv && (in_mode_ff == lpr_pkg::MODE_START);
   assign advance_en = stage_adv && (in_mode_ff == lpr_pkg::MODE_ADVANCE);

   lpr_setup u_setup (
      .req    (in_req_ff),
      .line   (setup_line),
      .at_end (setup_at_end)
   );

   lpr_stepper u_stepper (
      .clock        (clock),
      .reset        (reset),
      .start_en     (start_en),
      .advance_en   (advance_en),
      .setup_line   (setup_line),
      .setup_at_end (setup_at_end),
      .pixel        (pixel),
      .busy         (busy)
   );

   // The address wraps to its field width, so the product is kept at that width.
   assign pixel_addr = lpr_pkg::ADDR_W'(pixel.row) * lpr_pkg::ADDR_W'(FRAME_WIDTH)
                     + lpr_pkg::ADDR_W'(pixel.col);

   always_comb begin
      if (stage_adv) begin
         rsp_valid_in = pixel.valid;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_adv && pixel.valid) begin
         rsp_data_ff <= lpr_pkg::RSP_DATA_W'({pixel.color, pixel_addr, pixel.row, pixel.col});
         rsp_last_ff <= pixel.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // With the response register free, a held request always moves on.
   a_ready_when_out_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled while response register is empty");

   // An advance on an idle rasterizer changes nothing and gives no response.
   a_idle_advance: assert property (@(posedge clock) disable iff (reset)
      (advance_en && !busy) |=> (!busy && !rsp_tvalid))
      else $error("advance while idle produced activity");

   // Emitting the end point leaves the rasterizer idle.
   a_last_ends_line: assert property (@(posedge clock) disable iff (reset)
      (stage_adv && pixel.valid && pixel.last) |=> !busy)
      else $error("rasterizer still busy after last pixel");

endmodule
